FILE: src/vgpb_pkg.sv
// Shared types, constants and packet bit-order tables for the VFD grid packet builder.
package vgpb_pkg;

   localparam int ADDR_W       = 10;
   localparam int STORE_DEPTH  = 1 << ADDR_W;
   localparam int ROWS         = 39;
   localparam int ROW_W        = 6;
   localparam int PACKET_BYTES = 36;
   localparam int PACKET_BITS  = PACKET_BYTES * 8;
   localparam int GROUP_BITS   = 6;
   // every row feeds six consecutive packet bits; the tail past the rows is zero
   localparam int STEP_ROWS    = PACKET_BITS / GROUP_BITS;
   localparam int ENABLE_BASE  = 233;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [7:0] MASK_FIRST = 8'hFC;
   localparam logic [7:0] MASK_MID   = 8'h3C;
   localparam logic [7:0] MASK_LOW   = 8'h0C;

   typedef logic [2:0]                  sh_type;
   typedef sh_type [GROUP_BITS-1:0]     row_sh_type;
   typedef row_sh_type [ROWS-1:0]       sh_tab_type;

   // reorder tables a, b, c; [0] even grids, [1] odd grids; entry is a bit of the
   // group byte [a b c d e f 0 0], so codes 0 and 1 always give zero
   localparam sh_type ORD_TAB [3][2][6] = '{
      '{'{3'd0, 3'd2, 3'd0, 3'd3, 3'd0, 3'd4}, '{3'd7, 3'd0, 3'd6, 3'd0, 3'd5, 3'd0}},
      '{'{3'd0, 3'd3, 3'd0, 3'd4, 3'd0, 3'd2}, '{3'd6, 3'd0, 3'd5, 3'd0, 3'd7, 3'd0}},
      '{'{3'd0, 3'd4, 3'd0, 3'd2, 3'd0, 3'd3}, '{3'd5, 3'd0, 3'd7, 3'd0, 3'd6, 3'd0}}
   };

   // per row, the group bit that lands on each of its six packet bits;
   // packet bits run in 32-bit chunks cycling through tables a, b, c
   function automatic sh_tab_type build_sh_tab(input int odd);
      sh_tab_type  t;
      int unsigned p;
      t = '0;
      for (int r = 0; r < ROWS; r++) begin
         for (int j = 0; j < GROUP_BITS; j++) begin
            p       = r * GROUP_BITS + j;
            t[r][j] = ORD_TAB[(p / 32) % 3][odd][(p % 32) % 6];
         end
      end
      return t;
   endfunction

   localparam sh_tab_type SH_TAB_EVEN = build_sh_tab(0);
   localparam sh_tab_type SH_TAB_ODD  = build_sh_tab(1);

   typedef struct packed {
      logic             go;
      logic [5:0]       grid;
   } pk_cmd_type;

   typedef struct packed {
      logic             en;
      logic [ROW_W-1:0] row;
      logic [5:0]       group;
   } grp_wr_type;

endpackage

FILE: src/vgpb_packer.sv
// Column group store and packet serialiser: reads row groups and emits packet bytes.
module vgpb_packer (
   input  logic                clock,
   input  logic                reset,
   input  vgpb_pkg::pk_cmd_type cmd,
   input  vgpb_pkg::grp_wr_type grp_wr,
   output logic                rsp_valid,
   output logic [7:0]          rsp_packet_byte,
   output logic [5:0]          rsp_byte_index,
   output logic                rsp_last
);
   import vgpb_pkg::*;

   localparam int ACC_W = 14;

   logic [5:0] grp_mem [ROWS];
   logic [5:0] grp_rd_ff;

   logic             act_ff, act_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [5:0]       grid_ff, grid_in;
   logic             st_vld_ff, st_vld_in;
   logic             st_real_ff, st_real_in;
   logic [ROW_W-1:0] st_row_ff, st_row_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [5:0]       byte_ff, byte_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [5:0]       rsp_idx_ff, rsp_idx_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             rd_en;
   logic [ROW_W-1:0] tab_idx;
   row_sh_type       row_sh;
   logic [7:0]       grp8;
   logic [5:0]       bits6;
   logic [ACC_W-1:0] merged;
   logic [3:0]       ncnt;
   logic             emit;
   logic [8:0]       en0, en1;
   logic [7:0]       en_mask;

   assign rd_en = act_ff && (row_ff < ROW_W'(ROWS));

   always_ff @(posedge clock) begin
      if (grp_wr.en) begin
         grp_mem[grp_wr.row] <= grp_wr.group;
      end
      if (rd_en) begin
         grp_rd_ff <= grp_mem[row_ff];
      end
   end

   always_comb begin
      tab_idx = st_real_ff ? st_row_ff : '0;
      row_sh  = grid_ff[0] ? SH_TAB_ODD[tab_idx] : SH_TAB_EVEN[tab_idx];
      grp8    = {grp_rd_ff, 2'b00};
      for (int j = 0; j < GROUP_BITS; j++) begin
         bits6[j] = st_real_ff & grp8[row_sh[j]];
      end
      merged = acc_ff | (ACC_W'(bits6) << cnt_ff);
      ncnt   = cnt_ff + 4'd6;
      emit   = st_vld_ff && (ncnt >= 4'd8);

      // the two grid enable bits; past the packet end they never match a byte
      en0 = 9'(ENABLE_BASE) + 9'(grid_ff);
      en1 = en0 + 9'd1;
      for (int b = 0; b < 8; b++) begin
         en_mask[b] = ((en0[8:3] == byte_ff) && (en0[2:0] == 3'(b))) ||
                      ((en1[8:3] == byte_ff) && (en1[2:0] == 3'(b)));
      end
   end

   always_comb begin
      act_in       = act_ff;
      row_in       = row_ff;
      grid_in      = grid_ff;
      st_vld_in    = act_ff;
      st_real_in   = rd_en;
      st_row_in    = row_ff;
      acc_in       = acc_ff;
      cnt_in       = cnt_ff;
      byte_in      = byte_ff;
      rsp_valid_in = emit;
      rsp_byte_in  = merged[7:0] | en_mask;
      rsp_idx_in   = byte_ff;
      rsp_last_in  = (byte_ff == 6'(PACKET_BYTES - 1));

      if (st_vld_ff) begin
         if (emit) begin
            acc_in  = merged >> 8;
            cnt_in  = ncnt - 4'd8;
            byte_in = byte_ff + 6'd1;
         end else begin
            acc_in = merged;
            cnt_in = ncnt;
         end
      end

      if (act_ff) begin
         row_in = row_ff + ROW_W'(1);
         if (row_ff == ROW_W'(STEP_ROWS - 1)) begin
            act_in = 1'b0;
         end
      end

      if (cmd.go) begin
         act_in  = 1'b1;
         row_in  = '0;
         grid_in = cmd.grid;
         acc_in  = '0;
         cnt_in  = '0;
         byte_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff       <= 1'b0;
         st_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         byte_ff      <= '0;
         acc_ff       <= '0;
      end else begin
         act_ff       <= act_in;
         st_vld_ff    <= st_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         byte_ff      <= byte_in;
         acc_ff       <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      grid_ff     <= grid_in;
      st_real_ff  <= st_real_in;
      st_row_ff   <= st_row_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packet_byte = rsp_byte_ff;
   assign rsp_byte_index  = rsp_idx_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

FILE: src/vfd_grid_packet_builder.sv
// Top level: frame store, group fetch sequencer and packet serialiser.
// Write item: busy stays low. Render item: busy through 39 rows of one or two
// frame reads each, then through packing; the one-port frame store sets the
// fetch length. Packing gives 36 result items, which the receiver cannot
// stall. After reset a clearing pass zeroes the 1024-byte frame store, with
// busy high during it.
module vfd_grid_packet_builder #(
   parameter int ROW_BYTES = 20
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_operation,
   input  logic [vgpb_pkg::ADDR_W-1:0] req_frame_address,
   input  logic [7:0]                  req_frame_data,
   input  logic [5:0]                  req_grid,
   output logic                        rsp_valid,
   output logic [7:0]                  rsp_packet_byte,
   output logic [5:0]                  rsp_byte_index,
   output logic                        rsp_last
);
   import vgpb_pkg::*;

   // sequencer states
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_FETCH = 3'd2;
   localparam logic [2:0] ST_WAIT  = 3'd3;
   localparam logic [2:0] ST_PACK  = 3'd4;

   // frame store: one port, read data registered
   logic [7:0]        fs_mem [STORE_DEPTH];
   logic [7:0]        fs_rd_ff;
   logic              fs_we;
   logic [ADDR_W-1:0] fs_addr;
   logic [7:0]        fs_wdata;

   logic [2:0]        state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [5:0]        grid_ff, grid_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [ROW_W-1:0]  f_row_ff, f_row_in;
   logic              f_second_ff, f_second_in;
   logic              d_vld_ff, d_vld_in;
   logic              d_last_ff, d_last_in;
   logic [ROW_W-1:0]  d_row_ff, d_row_in;
   logic [7:0]        b0_ff, b0_in;

   logic [5:0]        req_g1;
   logic [5:0]        g1;
   logic [1:0]        mode;
   logic              two_rd;
   logic [ADDR_W-1:0] off0;
   logic [7:0]        grp_byte;

   pk_cmd_type        pk_cmd;
   grp_wr_type        grp_wr;

   // group position: x = ((grid-1)/8)*3 bytes into the row, mode from (grid-1) mod 8
   assign req_g1 = req_grid - 6'd1;
   assign g1     = grid_ff - 6'd1;
   assign mode   = g1[2:1];
   assign two_rd = (mode == 2'd1) || (mode == 2'd2);

   always_comb begin
      unique case (mode)
         2'd0, 2'd1: off0 = ADDR_W'(0);
         2'd2:       off0 = ADDR_W'(1);
         2'd3:       off0 = ADDR_W'(2);
         default:    off0 = ADDR_W'(0);
      endcase
   end

   // assemble the six pixels a..f into bits 7..2
   always_comb begin
      unique case (mode)
         2'd0:    grp_byte = fs_rd_ff & MASK_FIRST;
         2'd1:    grp_byte = {b0_ff[1:0], 6'd0} | ((fs_rd_ff >> 2) & MASK_MID);
         2'd2:    grp_byte = {b0_ff[3:0], 4'd0} | ((fs_rd_ff >> 4) & MASK_LOW);
         2'd3:    grp_byte = {fs_rd_ff[5:0], 2'b00};
         default: grp_byte = '0;
      endcase
   end

   assign grp_wr.en    = d_vld_ff && d_last_ff;
   assign grp_wr.row   = d_row_ff;
   assign grp_wr.group = grp_byte[7:2];

   assign pk_cmd.go   = (state_ff == ST_WAIT);
   assign pk_cmd.grid = grid_ff;

   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      grid_in     = grid_ff;
      base_in     = base_ff;
      f_row_in    = f_row_ff;
      f_second_in = f_second_ff;
      d_vld_in    = 1'b0;
      d_last_in   = !two_rd || f_second_ff;
      d_row_in    = f_row_ff;
      b0_in       = (d_vld_ff && !d_last_ff) ? fs_rd_ff : b0_ff;
      fs_we       = 1'b0;
      fs_addr     = base_ff + off0 + ADDR_W'(f_second_ff);
      fs_wdata    = req_frame_data;

      unique case (state_ff)
         ST_CLEAR: begin
            fs_we    = 1'b1;
            fs_addr  = clr_ff;
            fs_wdata = '0;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (req_operation == OP_WRITE) begin
                  fs_we   = 1'b1;
                  fs_addr = req_frame_address;
               end else begin
                  grid_in     = req_grid;
                  base_in     = ADDR_W'(req_g1[5:3]) * ADDR_W'(3);
                  f_row_in    = '0;
                  f_second_in = 1'b0;
                  state_in    = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            d_vld_in = 1'b1;
            if (two_rd && !f_second_ff) begin
               f_second_in = 1'b1;
            end else begin
               f_second_in = 1'b0;
               f_row_in    = f_row_ff + ROW_W'(1);
               base_in     = base_ff + ADDR_W'(ROW_BYTES);
               if (f_row_ff == ROW_W'(ROWS - 1)) begin
                  state_in = ST_WAIT;
               end
            end
         end
         ST_WAIT: begin
            // last group written this cycle; packer starts at the edge
            state_in = ST_PACK;
         end
         ST_PACK: begin
            if (rsp_valid && rsp_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[fs_addr] <= fs_wdata;
      end
      fs_rd_ff <= fs_mem[fs_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         d_vld_ff    <= 1'b0;
         f_second_ff <= 1'b0;
         f_row_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         clr_ff      <= clr_in;
         d_vld_ff    <= d_vld_in;
         f_second_ff <= f_second_in;
         f_row_ff    <= f_row_in;
      end
   end

   always_ff @(posedge clock) begin
      grid_ff   <= grid_in;
      base_ff   <= base_in;
      d_last_ff <= d_last_in;
      d_row_ff  <= d_row_in;
      b0_ff     <= b0_in;
   end

   assign busy = (state_ff != ST_IDLE);

   vgpb_packer u_packer (
      .clock           (clock),
      .reset           (reset),
      .cmd             (pk_cmd),
      .grp_wr          (grp_wr),
      .rsp_valid       (rsp_valid),
      .rsp_packet_byte (rsp_packet_byte),
      .rsp_byte_index  (rsp_byte_index),
      .rsp_last        (rsp_last)
   );

endmodule
